// ===== rtl/core/psu_pkg.sv =====
// Shared constants, codes and types for the PNG scanline unfilter core.
package psu_pkg;

	localparam int MAX_WIDTH    = 256;
	localparam int MAX_CHANNELS = 4;
	localparam int MAX_ROWS     = 256;
	localparam int HIST_DEPTH   = 4;
	localparam int BYTE_W       = 8;
	localparam int CFG_W        = 9;
	localparam int BPP_W        = 3;
	localparam int ROW_W        = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int TAP_W        = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BPP    = 2'd2;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	// one beat handed from the sequencer to the reconstruct stage
	typedef struct packed {
		logic                 is_bad;
		logic [BYTE_W-1:0]    data_byte;
		filter_t              filter;
		logic                 has_left;
		logic                 has_above;
		logic [TAP_W-1:0]     tap;
		logic                 row_done;
		logic                 image_done;
	} item_t;

endpackage

// ===== rtl/core/psu_in_if.sv =====
// Input byte stream channel.
interface psu_in_if;
	logic                          valid;
	logic                          ready;
	logic [psu_pkg::BYTE_W-1:0]    data_byte;
	logic                          image_start;

	modport source (output valid, output data_byte, output image_start, input ready);
	modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

// ===== rtl/core/psu_out_if.sv =====
// Reconstructed sample channel.
interface psu_out_if;
	logic                          valid;
	logic                          ready;
	logic [psu_pkg::BYTE_W-1:0]    sample_value;
	logic                          row_done;
	logic                          image_done;
	logic                          bad_filter;

	modport source (output valid, output sample_value, output row_done, output image_done,
		output bad_filter, input ready);
	modport sink   (input valid, input sample_value, input row_done, input image_done,
		input bad_filter, output ready);
endinterface

// ===== rtl/core/psu_cfg_if.sv =====
// Configuration register write channel.
interface psu_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [psu_pkg::CFG_IDX_W-1:0]   index;
	logic [psu_pkg::CFG_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/png_scanline_unfilter_core.sv =====
// PNG scanline unfilter core: top level joining sequencer, line store and reconstruct stage.
//
// Takes the inflated PNG stream one byte per beat on pix_in and gives one reconstructed
// byte per filtered sample on pix_out. Each row is a filter-type byte (None, Sub, Up,
// Average, Paeth) followed by width * bytes_per_pixel samples; filter-type bytes give no
// output beat. A filter byte above 4 gives one beat with bad_filter set and all other
// fields zero, and every later byte is dropped until a beat with image_start. After the
// last row the core waits for the next image's first filter byte without needing
// image_start. Throughput is one byte per clock sustained while pix_out is ready: the only
// loop is the line-store read of "above" followed by predictor and add, which completes in
// the single reconstruct stage, and each line-store entry is written a full row before it is
// read again. An accepted sample passes the registered memory read, then output register.
// The output register decouples the sides, so a new byte is accepted while a result waits if
// the reconstruct stage is empty. The line store needs no clearing after reset; the first
// row of an image reads above and above-left as zero. Configuration (index 0 width,
// 1 height, 2 bytes_per_pixel) is taken every cycle and must be written only while idle.
// Register values out of range are clamped at use; bytes_per_pixel keeps its low three bits.
module png_scanline_unfilter_core #(
	parameter int MAX_WIDTH    = psu_pkg::MAX_WIDTH,
	parameter int MAX_CHANNELS = psu_pkg::MAX_CHANNELS
) (
	input  logic       clk,
	input  logic       arst_n,
	psu_in_if.sink     pix_in,
	psu_out_if.source  pix_out,
	psu_cfg_if.sink    cfg
);

	localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// accept-stage handoff
	logic                       take, issue;
	psu_pkg::item_t             item;
	logic [AW-1:0]              addr;

	// line store ports
	logic [psu_pkg::BYTE_W-1:0] rd_data, wr_data;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;

	psu_ctrl #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.DEPTH        (DEPTH),
		.AW           (AW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in),
		.cfg    (cfg),
		.take   (take),
		.issue  (issue),
		.item   (item),
		.addr   (addr)
	);

	// "above" read issued with the accepted beat, data lands for the reconstruct stage
	psu_line_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.rd_en   (issue),
		.rd_addr (addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	psu_recon #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_recon (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.issue   (issue),
		.item    (item),
		.addr    (addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.pix_out (pix_out)
	);

endmodule

// ===== rtl/core/psu_line_store.sv =====
// Previous-row line store: one write port, one registered read port.
module psu_line_store #(
	parameter int DEPTH = psu_pkg::MAX_WIDTH * psu_pkg::MAX_CHANNELS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [psu_pkg::BYTE_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [psu_pkg::BYTE_W-1:0] wr_data
);

	logic [psu_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [psu_pkg::BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/psu_ctrl.sv =====
// Config registers and stream sequencer: filter byte parsing, column/row position.
module psu_ctrl #(
	parameter int MAX_WIDTH    = psu_pkg::MAX_WIDTH,
	parameter int MAX_CHANNELS = psu_pkg::MAX_CHANNELS,
	parameter int DEPTH        = MAX_WIDTH * MAX_CHANNELS,
	parameter int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	psu_in_if.sink           pix_in,
	psu_cfg_if.sink          cfg,
	input  logic             take,
	output logic             issue,
	output psu_pkg::item_t   item,
	output logic [AW-1:0]    addr
);

	localparam int SW0 = $clog2(DEPTH + 1);
	localparam int SW  = (SW0 > psu_pkg::CFG_W) ? SW0 : psu_pkg::CFG_W;
	localparam int PW  = SW + psu_pkg::BPP_W;

	logic [psu_pkg::CFG_W-1:0] width_q, height_q;
	logic [psu_pkg::BPP_W-1:0] bpp_q;

	logic [AW-1:0]              col_q;
	logic [psu_pkg::ROW_W-1:0]  row_q;
	psu_pkg::filter_t           filt_q;
	logic                       await_q, first_q, err_q;

	logic [AW-1:0]              cur_col;
	logic [psu_pkg::ROW_W-1:0]  cur_row;
	psu_pkg::filter_t           cur_filt;
	logic                       cur_await, cur_first, cur_err;

	logic [SW-1:0]              w, stride, x_ext, x_next;
	logic [PW-1:0]              prod;
	logic [psu_pkg::BPP_W-1:0]  bpp;
	logic [psu_pkg::CFG_W-1:0]  h, row_inc;
	logic [AW-1:0]              x;
	logic                       acc, bad, row_end, img_end;

	logic [AW-1:0]              col_d;
	logic [psu_pkg::ROW_W-1:0]  row_d;
	psu_pkg::filter_t           filt_d;
	logic                       await_d, first_d, err_d;

	// config writes, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= psu_pkg::CFG_W'(1);
			height_q <= psu_pkg::CFG_W'(1);
			bpp_q    <= psu_pkg::BPP_W'(4);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				psu_pkg::REG_WIDTH:  width_q  <= cfg.data;
				psu_pkg::REG_HEIGHT: height_q <= cfg.data;
				psu_pkg::REG_BPP:    bpp_q    <= cfg.data[psu_pkg::BPP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped geometry
	always_comb begin
		w = SW'(width_q);
		if (width_q == '0) begin
			w = SW'(1);
		end else if (SW'(width_q) > SW'(MAX_WIDTH)) begin
			w = SW'(MAX_WIDTH);
		end
		bpp = bpp_q;
		if (bpp_q == '0) begin
			bpp = psu_pkg::BPP_W'(1);
		end else if (bpp_q > psu_pkg::BPP_W'(MAX_CHANNELS)) begin
			bpp = psu_pkg::BPP_W'(MAX_CHANNELS);
		end
		h = height_q;
		if (height_q == '0) begin
			h = psu_pkg::CFG_W'(1);
		end else if (height_q > psu_pkg::CFG_W'(psu_pkg::MAX_ROWS)) begin
			h = psu_pkg::CFG_W'(psu_pkg::MAX_ROWS);
		end
		prod   = {{psu_pkg::BPP_W{1'b0}}, w} * {{SW{1'b0}}, bpp};
		stride = prod[SW-1:0];
	end

	assign acc = pix_in.valid & take;
	assign pix_in.ready = take;

	always_comb begin
		// image start restarts position before the byte is used
		if (pix_in.image_start) begin
			cur_col   = '0;
			cur_row   = '0;
			cur_filt  = psu_pkg::FILT_NONE;
			cur_await = 1'b1;
			cur_first = 1'b1;
			cur_err   = 1'b0;
		end else begin
			cur_col   = col_q;
			cur_row   = row_q;
			cur_filt  = filt_q;
			cur_await = await_q;
			cur_first = first_q;
			cur_err   = err_q;
		end

		x       = (SW'(cur_col) >= stride) ? '0 : cur_col;
		x_ext   = SW'(x);
		x_next  = x_ext + SW'(1);
		row_end = (x_next >= stride);
		row_inc = psu_pkg::CFG_W'(cur_row) + psu_pkg::CFG_W'(1);
		img_end = (row_inc >= h);
		bad     = (pix_in.data_byte > psu_pkg::BYTE_W'(psu_pkg::FILT_PAETH));

		col_d   = cur_col;
		row_d   = cur_row;
		filt_d  = cur_filt;
		await_d = cur_await;
		first_d = cur_first;
		err_d   = cur_err;
		issue   = 1'b0;

		if (!cur_err) begin
			if (cur_await) begin
				if (bad) begin
					err_d = 1'b1;
					issue = acc;
				end else begin
					filt_d  = psu_pkg::filter_t'(pix_in.data_byte[2:0]);
					await_d = 1'b0;
					col_d   = '0;
				end
			end else begin
				issue = acc;
				col_d = row_end ? '0 : x_next[AW-1:0];
				if (row_end) begin
					await_d = 1'b1;
					if (img_end) begin
						row_d   = '0;
						first_d = 1'b1;
					end else begin
						row_d   = row_inc[psu_pkg::ROW_W-1:0];
						first_d = 1'b0;
					end
				end
			end
		end

		item.is_bad     = cur_await;
		item.data_byte  = pix_in.data_byte;
		item.filter     = cur_filt;
		item.has_left   = (x_ext >= SW'(bpp));
		item.has_above  = !cur_first;
		item.tap        = psu_pkg::TAP_W'(bpp - psu_pkg::BPP_W'(1));
		item.row_done   = !cur_await & row_end;
		item.image_done = !cur_await & row_end & img_end;
		addr            = x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			filt_q  <= psu_pkg::FILT_NONE;
			await_q <= 1'b1;
			first_q <= 1'b1;
			err_q   <= 1'b0;
		end else if (acc) begin
			col_q   <= col_d;
			row_q   <= row_d;
			filt_q  <= filt_d;
			await_q <= await_d;
			first_q <= first_d;
			err_q   <= err_d;
		end
	end

endmodule

// ===== rtl/core/psu_recon.sv =====
// Reconstruct stage: predictor, modulo-256 add, byte histories and output register.
module psu_recon #(
	parameter int DEPTH = psu_pkg::MAX_WIDTH * psu_pkg::MAX_CHANNELS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	output logic                       take,
	input  logic                       issue,
	input  psu_pkg::item_t             item,
	input  logic [AW-1:0]              addr,
	input  logic [psu_pkg::BYTE_W-1:0] rd_data,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [psu_pkg::BYTE_W-1:0] wr_data,
	psu_out_if.source                  pix_out
);

	localparam int BW = psu_pkg::BYTE_W;

	logic               valid_s1;
	psu_pkg::item_t     item_s1;
	logic [AW-1:0]      addr_s1;

	logic [BW-1:0]      left_q    [psu_pkg::HIST_DEPTH];
	logic [BW-1:0]      up_left_q [psu_pkg::HIST_DEPTH];

	logic               out_valid_q;
	logic [BW-1:0]      out_sample_q;
	logic               out_row_q, out_img_q, out_bad_q;

	logic               adv, commit;
	logic [BW-1:0]      left, up, up_left, pred, value;
	logic [BW:0]        sum_ab, two_c;
	logic [BW:0]        pa, pb, pc;

	assign adv  = !out_valid_q || pix_out.ready;
	assign take = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (take && issue) begin
			item_s1 <= item;
			addr_s1 <= addr;
		end
	end

	always_comb begin
		up      = item_s1.has_above ? rd_data : '0;
		left    = item_s1.has_left ? left_q[item_s1.tap] : '0;
		up_left = (item_s1.has_above && item_s1.has_left) ? up_left_q[item_s1.tap] : '0;

		// Paeth distances, p = a + b - c
		sum_ab = {1'b0, left} + {1'b0, up};
		two_c  = {up_left, 1'b0};
		pa = (up >= up_left) ? {1'b0, up - up_left} : {1'b0, up_left - up};
		pb = (left >= up_left) ? {1'b0, left - up_left} : {1'b0, up_left - left};
		pc = (sum_ab >= two_c) ? (sum_ab - two_c) : (two_c - sum_ab);

		case (item_s1.filter)
			psu_pkg::FILT_SUB:   pred = left;
			psu_pkg::FILT_UP:    pred = up;
			psu_pkg::FILT_AVG:   pred = sum_ab[BW:1];
			psu_pkg::FILT_PAETH: begin
				if (pa <= pb && pa <= pc) begin
					pred = left;
				end else if (pb <= pc) begin
					pred = up;
				end else begin
					pred = up_left;
				end
			end
			default:             pred = '0;
		endcase
		value = item_s1.data_byte + pred;
	end

	assign commit  = valid_s1 && adv && !item_s1.is_bad;
	assign wr_en   = commit;
	assign wr_addr = addr_s1;
	assign wr_data = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psu_pkg::HIST_DEPTH; i++) begin
				left_q[i]    <= '0;
				up_left_q[i] <= '0;
			end
		end else if (commit) begin
			for (int i = 1; i < psu_pkg::HIST_DEPTH; i++) begin
				left_q[i]    <= left_q[i-1];
				up_left_q[i] <= up_left_q[i-1];
			end
			left_q[0]    <= value;
			up_left_q[0] <= up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_sample_q <= item_s1.is_bad ? '0 : value;
			out_row_q    <= !item_s1.is_bad && item_s1.row_done;
			out_img_q    <= !item_s1.is_bad && item_s1.image_done;
			out_bad_q    <= item_s1.is_bad;
		end
	end

	assign pix_out.valid        = out_valid_q;
	assign pix_out.sample_value = out_sample_q;
	assign pix_out.row_done     = out_row_q;
	assign pix_out.image_done   = out_img_q;
	assign pix_out.bad_filter   = out_bad_q;

endmodule
